### rtl/core/cop0tlb_pkg.sv
// Shared types and constants for the coprocessor-0 register and TLB write block.
// No dependencies.
package cop0tlb_pkg;

  localparam int TLB_ENTRIES = 48;
  localparam int TLB_AW = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;

  localparam logic [4:0] RS_MFC   = 5'h00;
  localparam logic [4:0] RS_MTC   = 5'h04;
  localparam logic [4:0] RS_TLBWI = 5'h10;

  localparam logic [4:0] REG_INDEX    = 5'd0;
  localparam logic [4:0] REG_ENTRYLO0 = 5'd2;
  localparam logic [4:0] REG_ENTRYLO1 = 5'd3;
  localparam logic [4:0] REG_PAGEMASK = 5'd5;
  localparam logic [4:0] REG_COUNT    = 5'd9;
  localparam logic [4:0] REG_ENTRYHI  = 5'd10;

  typedef struct packed {
    logic        en;
    logic [4:0]  rd;
    logic [63:0] data;
    logic [63:0] now;
  } reg_wr_t;

  typedef struct packed {
    logic [63:0] lo0;
    logic [63:0] lo1;
    logic [63:0] hi;
    logic [63:0] mask;
  } tlb_rec_t;

  typedef struct packed {
    logic              en;
    logic [TLB_AW-1:0] addr;
  } tlb_wr_t;

endpackage

### rtl/core/cop0_register_and_tlb_write.sv
// Coprocessor-0 MFC0 / MTC0 / TLBWI execution unit, top level.
// Each instruction is captured in the s1 input register, executes from there and lands in the result register.
// Throughput: one instruction per cycle while results are accepted; state is written in the execute cycle.
// Reset clears cop0 registers, count base and both pipeline valids.
// TLB contents are undefined until written; no clearing pass.
// Depends on cop0tlb_pkg, cop0tlb_regfile, cop0tlb_tlb.
module cop0_register_and_tlb_write (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] instr_word,
  input  logic [63:0] gpr_value,
  input  logic [63:0] cycle_now,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        gpr_write_enable,
  output logic [63:0] gpr_write_data,
  output logic        bad_tlb_index,
  output logic        unknown_op
);
  import cop0tlb_pkg::*;

  logic        s1_valid;
  logic [31:0] s1_instr;
  logic [63:0] s1_gpr;
  logic [63:0] s1_now;

  logic        advance;
  logic        exec;
  logic [4:0]  rs;
  logic [4:0]  rt;
  logic [4:0]  rd;
  logic        is_mfc;
  logic        is_mtc;
  logic        is_tlbwi;
  logic        idx_bad;

  reg_wr_t     reg_wr;
  tlb_wr_t     tlb_wr;
  tlb_rec_t    tlb_rec;
  logic [7:0]  tlb_index;
  logic [63:0] rd_data;

  logic        we_next;
  logic [63:0] data_next;

  assign advance  = !out_valid || out_ready;
  assign in_ready = !s1_valid || advance;
  assign exec     = s1_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_instr <= instr_word;
      s1_gpr   <= gpr_value;
      s1_now   <= cycle_now;
    end
  end

  assign rs = s1_instr[25:21];
  assign rt = s1_instr[20:16];
  assign rd = s1_instr[15:11];

  assign is_mfc   = (rs == RS_MFC);
  assign is_mtc   = (rs == RS_MTC);
  assign is_tlbwi = (rs == RS_TLBWI);
  assign idx_bad  = (tlb_index >= 8'(TLB_ENTRIES));

  assign reg_wr.en   = exec && is_mtc;
  assign reg_wr.rd   = rd;
  assign reg_wr.data = s1_gpr;
  assign reg_wr.now  = s1_now;

  assign tlb_wr.en   = exec && is_tlbwi && !idx_bad;
  assign tlb_wr.addr = tlb_index[TLB_AW-1:0];

  cop0tlb_regfile u_regfile (
    .clk       (clk),
    .rst       (rst),
    .wr        (reg_wr),
    .rd_addr   (rd),
    .rd_now    (s1_now),
    .rd_data   (rd_data),
    .tlb_index (tlb_index),
    .tlb_rec   (tlb_rec)
  );

  cop0tlb_tlb u_tlb (
    .clk   (clk),
    .wr    (tlb_wr),
    .entry (tlb_rec)
  );

  assign we_next   = is_mfc && (rt != 5'd0);
  assign data_next = we_next ? rd_data : 64'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      gpr_write_enable <= we_next;
      gpr_write_data   <= data_next;
      bad_tlb_index    <= is_tlbwi && idx_bad;
      unknown_op       <= !(is_mfc || is_mtc || is_tlbwi);
    end
  end

`ifndef NO_ASSERTIONS
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(gpr_write_enable && (bad_tlb_index || unknown_op))
      && !(bad_tlb_index && unknown_op))
    else $error("conflicting result flags");

  a_data_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !gpr_write_enable) |-> (gpr_write_data == 64'd0))
    else $error("write data not zero without write enable");

  a_state_write_on_exec: assert property (@(posedge clk) disable iff (rst)
    (reg_wr.en || tlb_wr.en) |-> (exec && !(reg_wr.en && tlb_wr.en)))
    else $error("state write outside execute");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> (!s1_valid && !out_valid))
    else $error("pipeline not empty after reset");

  a_exec_fills_output: assert property (@(posedge clk) disable iff (rst)
    exec |=> out_valid)
    else $error("executed beat did not reach result register");
`endif

endmodule

### rtl/core/cop0tlb_regfile.sv
// Coprocessor-0 register file with Count derived from the cycle counter.
// Depends on cop0tlb_pkg.
module cop0tlb_regfile (
  input  logic                    clk,
  input  logic                    rst,
  input  cop0tlb_pkg::reg_wr_t    wr,
  input  logic [4:0]              rd_addr,
  input  logic [63:0]             rd_now,
  output logic [63:0]             rd_data,
  output logic [7:0]              tlb_index,
  output cop0tlb_pkg::tlb_rec_t   tlb_rec
);
  import cop0tlb_pkg::*;

  logic [63:0] regs [32];
  logic [63:0] count_base;
  logic [63:0] elapsed;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 32; i++) regs[i] <= '0;
      count_base <= '0;
    end else if (wr.en) begin
      regs[wr.rd] <= wr.data;
      if (wr.rd == REG_COUNT) begin
        count_base <= wr.now - {31'b0, wr.data[31:0], 1'b0};
      end
    end
  end

  assign elapsed = rd_now - count_base;
  assign rd_data = (rd_addr == REG_COUNT) ? {32'b0, elapsed[32:1]} : regs[rd_addr];

  assign tlb_index    = regs[REG_INDEX][7:0];
  assign tlb_rec.lo0  = regs[REG_ENTRYLO0];
  assign tlb_rec.lo1  = regs[REG_ENTRYLO1];
  assign tlb_rec.hi   = regs[REG_ENTRYHI];
  assign tlb_rec.mask = regs[REG_PAGEMASK];

endmodule

### rtl/core/cop0tlb_tlb.sv
// TLB entry storage, written by TLBWI; contents undefined until written.
// Depends on cop0tlb_pkg.
module cop0tlb_tlb (
  input  logic                    clk,
  input  cop0tlb_pkg::tlb_wr_t    wr,
  input  cop0tlb_pkg::tlb_rec_t   entry
);
  import cop0tlb_pkg::*;

  tlb_rec_t mem [TLB_ENTRIES];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= entry;
    end
  end

endmodule

### tb/cop0_register_and_tlb_write_tb.sv
// Testbench for cop0_register_and_tlb_write: queue-fed driver, clocked monitor, and a
// behavioral mirror of the cop0 registers and Count origin that predicts each result.
// Depends on cop0tlb_pkg and the cop0_register_and_tlb_write RTL.
`timescale 1ns / 1ps

module cop0_register_and_tlb_write_tb;
  import cop0tlb_pkg::*;

  typedef struct packed {
    logic [31:0] word;
    logic [63:0] gpr;
    logic [63:0] now;
  } beat_t;

  typedef struct packed {
    logic        we;
    logic [63:0] data;
    logic        bad;
    logic        unk;
  } wb_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] instr_word = '0;
  logic [63:0] gpr_value = '0;
  logic [63:0] cycle_now = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        gpr_write_enable;
  logic [63:0] gpr_write_data;
  logic        bad_tlb_index;
  logic        unknown_op;

  beat_t       instr_q[$];
  wb_t         wb_expect_q[$];
  logic [63:0] cop0_mirror[32];
  logic [63:0] count_origin;
  logic [63:0] tick;
  int          err_cnt = 0;
  int          out_cnt = 0;
  int          drv_gap = 0;
  int          drv_calm = 0;
  int          rcv_gap = 0;
  int          rcv_calm = 0;
  int          run_cyc = 0;
  logic        stall_hold = 1'b0;

  cop0_register_and_tlb_write uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .instr_word(instr_word),
    .gpr_value(gpr_value),
    .cycle_now(cycle_now),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .gpr_write_enable(gpr_write_enable),
    .gpr_write_data(gpr_write_data),
    .bad_tlb_index(bad_tlb_index),
    .unknown_op(unknown_op)
  );

  always #10 clk = ~clk;

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [31:0] cop0_word(logic [4:0] rs, logic [4:0] rt, logic [4:0] rd);
    logic [31:0] r;
    r = $urandom;
    return {r[31:26], rs, rt, rd, r[10:0]};
  endfunction

  task automatic exec_cop0(input beat_t b, output wb_t res);
    logic [4:0]  rs, rt, rd;
    logic [63:0] elapsed;
    rs = b.word[25:21];
    rt = b.word[20:16];
    rd = b.word[15:11];
    res = '0;
    case (rs)
      RS_MFC: begin
        if (rt != 5'd0) begin
          res.we = 1'b1;
          if (rd == REG_COUNT) begin
            elapsed = b.now - count_origin;
            res.data = {32'd0, elapsed[32:1]};
          end else begin
            res.data = cop0_mirror[rd];
          end
        end
      end
      RS_MTC: begin
        cop0_mirror[rd] = b.gpr;
        if (rd == REG_COUNT) count_origin = b.now - {31'd0, b.gpr[31:0], 1'b0};
      end
      RS_TLBWI: begin
        if (cop0_mirror[REG_INDEX][7:0] >= TLB_ENTRIES) res.bad = 1'b1;
      end
      default: res.unk = 1'b1;
    endcase
  endtask

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch: %s at result %0d: got %h want %h", field, out_cnt, got, want);
    err_cnt++;
  endtask

  task automatic push_beat(input logic [31:0] word, input logic [63:0] gpr,
                           input logic [63:0] now);
    instr_q.push_back('{word: word, gpr: gpr, now: now});
  endtask

  // running cycle count, with an occasional jump anywhere in the 64-bit range
  function automatic logic [63:0] next_now();
    tick = tick + 64'($urandom_range(0, 6));
    if ($urandom_range(0, 9) == 0) return rand64();
    return tick;
  endfunction

  task automatic push_op(input logic [4:0] rs, input logic [4:0] rt, input logic [4:0] rd,
                         input logic [63:0] gpr);
    push_beat(cop0_word(rs, rt, rd), gpr, next_now());
  endtask

  function automatic logic [63:0] pick_index();
    int r;
    logic [63:0] v;
    r = $urandom_range(0, 3);
    v = rand64();
    if (r < 2) return {v[63:8], 8'($urandom_range(0, TLB_ENTRIES - 1))};
    if (r == 2) return {v[63:8], 8'($urandom_range(TLB_ENTRIES, 255))};
    return v;
  endfunction

  task automatic push_tlb_seq();
    logic [4:0] regs[5];
    logic [4:0] t;
    int j;
    regs[0] = REG_INDEX;
    regs[1] = REG_ENTRYLO0;
    regs[2] = REG_ENTRYLO1;
    regs[3] = REG_ENTRYHI;
    regs[4] = REG_PAGEMASK;
    for (int i = 4; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = regs[i];
      regs[i] = regs[j];
      regs[j] = t;
    end
    for (int i = 0; i < 5; i++)
      if ($urandom_range(0, 5) != 0)
        push_op(RS_MTC, 5'($urandom), regs[i], (regs[i] == REG_INDEX) ? pick_index() : rand64());
    push_op(RS_TLBWI, 5'($urandom), 5'($urandom), rand64());
    if ($urandom_range(0, 1) == 0)
      push_op(RS_MFC, 5'($urandom_range(1, 31)), regs[$urandom_range(0, 4)], rand64());
  endtask

  task automatic push_count_seq();
    int n;
    if ($urandom_range(0, 3) != 0) push_op(RS_MTC, 5'($urandom), REG_COUNT, rand64());
    n = $urandom_range(1, 4);
    for (int i = 0; i < n; i++)
      push_op(RS_MFC, 5'($urandom_range(0, 7) == 0 ? 0 : $urandom_range(1, 31)), REG_COUNT,
              rand64());
  endtask

  task automatic push_single();
    int r;
    logic [4:0] rs;
    r = $urandom_range(0, 99);
    if (r < 40) rs = RS_MFC;
    else if (r < 75) rs = RS_MTC;
    else if (r < 85) rs = RS_TLBWI;
    else rs = 5'($urandom);
    push_op(rs, 5'($urandom_range(0, 9) == 0 ? 0 : $urandom), 5'($urandom), rand64());
  endtask

  task automatic build_stimulus();
    int r;
    tick = 64'd100;
    // reads straight after reset
    push_beat(cop0_word(RS_MFC, 5'd5, REG_INDEX), rand64(), 64'd10);
    push_beat(cop0_word(RS_MFC, 5'd1, REG_COUNT), rand64(), 64'hFFFF_FFFF_FFFF_FFFF);
    push_beat(cop0_word(RS_MFC, 5'd0, REG_ENTRYHI), rand64(), 64'd20);
    // TLB setup and in-range writes at both ends of the table
    push_beat(cop0_word(RS_MTC, 5'd3, REG_INDEX), 64'd0, 64'd30);
    push_beat(cop0_word(RS_MTC, 5'd0, REG_ENTRYLO0), '1, 64'd31);
    push_beat(cop0_word(RS_MTC, 5'd31, REG_ENTRYLO1), {32{2'b10}}, 64'd32);
    push_beat(cop0_word(RS_MTC, 5'd7, REG_ENTRYHI), {32{2'b01}}, 64'd33);
    push_beat(cop0_word(RS_MTC, 5'd9, REG_PAGEMASK), 64'h0000_0000_01FF_E000, 64'd34);
    push_beat(cop0_word(RS_TLBWI, 5'd0, 5'd0), 64'd0, 64'd35);
    push_beat(cop0_word(RS_MTC, 5'd1, REG_INDEX), 64'd47, 64'd36);
    push_beat(cop0_word(RS_TLBWI, 5'd31, 5'd31), '1, 64'd37);
    // index just past the end, and high bits that the index ignores
    push_beat(cop0_word(RS_MTC, 5'd1, REG_INDEX), 64'd48, 64'd38);
    push_beat(cop0_word(RS_TLBWI, 5'd0, 5'd0), 64'd0, 64'd39);
    push_beat(cop0_word(RS_MTC, 5'd1, REG_INDEX), 64'hFFFF_FFFF_FFFF_FF05, 64'd40);
    push_beat(cop0_word(RS_TLBWI, 5'd0, 5'd0), 64'd0, 64'd41);
    push_beat(cop0_word(RS_MTC, 5'd1, REG_INDEX), 64'h0000_0000_0000_00FF, 64'd42);
    push_beat(cop0_word(RS_TLBWI, 5'd0, 5'd0), 64'd0, 64'd43);
    push_beat(cop0_word(RS_MFC, 5'd2, REG_INDEX), 64'd0, 64'd44);
    // Count writes and reads, across the 64-bit wrap
    push_beat(cop0_word(RS_MTC, 5'd0, REG_COUNT), '1, 64'd5);
    push_beat(cop0_word(RS_MFC, 5'd31, REG_COUNT), 64'd0, 64'd9);
    push_beat(cop0_word(RS_MTC, 5'd0, REG_COUNT), 64'd0, '1);
    push_beat(cop0_word(RS_MFC, 5'd4, REG_COUNT), 64'd0, 64'd0);
    push_beat(cop0_word(RS_MFC, 5'd0, REG_COUNT), 64'd0, 64'd7);
    push_beat(cop0_word(RS_MTC, 5'd0, 5'd31), '1, 64'd50);
    push_beat(cop0_word(RS_MFC, 5'd31, 5'd31), 64'd0, 64'd51);
    push_beat(cop0_word(5'd1, 5'd1, 5'd1), '1, 64'd52);
    push_beat(cop0_word(5'd31, 5'd31, 5'd31), '1, '1);
    while (instr_q.size() < 550) begin
      r = $urandom_range(0, 99);
      if (r < 25) push_tlb_seq();
      else if (r < 45) push_count_seq();
      else push_single();
    end
  endtask

  always @(posedge clk) begin
    run_cyc <= rst ? 0 : run_cyc + 1;
    stall_hold <= !rst && run_cyc >= 300 && run_cyc < 400;
  end

  always @(posedge clk) begin
    beat_t b;
    wb_t res;
    logic nxt_valid;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        exec_cop0('{word: instr_word, gpr: gpr_value, now: cycle_now}, res);
        wb_expect_q.push_back(res);
      end
      if (!(in_valid && !in_ready)) begin
        nxt_valid = 1'b0;
        if (drv_gap > 0) begin
          drv_gap--;
        end else if (instr_q.size() > 0) begin
          b = instr_q.pop_front();
          instr_word <= b.word;
          gpr_value <= b.gpr;
          cycle_now <= b.now;
          nxt_valid = 1'b1;
          if (drv_calm > 0) begin
            drv_calm--;
          end else begin
            drv_gap = pick_gap();
            if ($urandom_range(0, 39) == 0) drv_calm = 40;
          end
        end
        in_valid <= nxt_valid;
      end
    end
  end

  always @(posedge clk) begin
    wb_t e;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (wb_expect_q.size() == 0) begin
          report_mismatch("unexpected result", gpr_write_data, 64'd0);
        end else begin
          e = wb_expect_q.pop_front();
          if (gpr_write_enable !== e.we) report_mismatch("gpr_write_enable", 64'(gpr_write_enable), 64'(e.we));
          if (gpr_write_data !== e.data) report_mismatch("gpr_write_data", gpr_write_data, e.data);
          if (bad_tlb_index !== e.bad) report_mismatch("bad_tlb_index", 64'(bad_tlb_index), 64'(e.bad));
          if (unknown_op !== e.unk) report_mismatch("unknown_op", 64'(unknown_op), 64'(e.unk));
        end
        out_cnt++;
        if (rcv_calm > 0) begin
          rcv_calm--;
        end else begin
          rcv_gap = pick_gap();
          if ($urandom_range(0, 39) == 0) rcv_calm = 40;
        end
      end
      if (stall_hold) begin
        out_ready <= 1'b0;
      end else if (rcv_gap > 0) begin
        rcv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    for (int i = 0; i < 32; i++) cop0_mirror[i] = '0;
    count_origin = '0;
    build_stimulus();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (instr_q.size() != 0 || in_valid || wb_expect_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (err_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #(400000 * 20);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
